// ===== rtl/core/bmab_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear mask alpha blend package
// Field widths, stream payload layouts and register codes that are shared by
// the blend pipeline and its users.
// ----------------------------------------------------------------------------
package bmab_pkg;

   // Mask store geometry.
   localparam int MASK_DIM    = 64;
   localparam int MASK_AW     = $clog2(MASK_DIM);
   localparam int BANK_AW     = 2 * (MASK_AW - 1);
   localparam int BANK_DEPTH  = 2 ** BANK_AW;
   localparam int NUM_BANKS   = 4;
   localparam int MASK_LIMIT  = 49;
   localparam int MASK_OFFSET = 2;

   // Pixel coordinates and region size.
   localparam int MAX_REGION = 4096;
   localparam int COORD_W    = $clog2(MAX_REGION);
   localparam int REGION_W   = COORD_W + 1;

   // Q8 weights and color channels.
   localparam int WEIGHT_W = 9;
   localparam int FRAC_W   = 8;
   localparam int Q8_ONE   = 256;
   localparam int CHAN_W   = 8;

   // Scale registers.
   localparam int SCALE_W   = 4;
   localparam int SHIFT_MAX = 8;

   // Request payload: fields from the lowest bit up, padded to whole bytes.
   localparam int REQ_FIELDS_W = 2 * MASK_AW + WEIGHT_W + 2 * COORD_W + 6 * CHAN_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_PAD_W    = REQ_TDATA_W - REQ_FIELDS_W;
   localparam int RSP_TDATA_W  = 3 * CHAN_W;

   // Packed structs list their members from the highest bit down.
   typedef struct packed {
      logic [REQ_PAD_W-1:0] pad;
      logic [CHAN_W-1:0]    src_blue;
      logic [CHAN_W-1:0]    src_green;
      logic [CHAN_W-1:0]    src_red;
      logic [CHAN_W-1:0]    dest_blue;
      logic [CHAN_W-1:0]    dest_green;
      logic [CHAN_W-1:0]    dest_red;
      logic [COORD_W-1:0]   pixel_row;
      logic [COORD_W-1:0]   pixel_col;
      logic [WEIGHT_W-1:0]  weight;
      logic [MASK_AW-1:0]   mask_y;
      logic [MASK_AW-1:0]   mask_x;
   } req_data_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
   } rsp_data_type;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_SCALE_X  = 2'd0,
      CSR_SCALE_Y  = 2'd1,
      CSR_REGION_W = 2'd2,
      CSR_REGION_H = 2'd3
   } csr_index_type;

endpackage

// ===== rtl/core/bilinear_mask_alpha_blend.sv =====
// ----------------------------------------------------------------------------
// Bilinear mask alpha blend
// Blends a source RGB888 pixel into a destination pixel with a Q8 weight that
// is interpolated bilinearly from a 64 x 64 mask store filled by load items.
// ----------------------------------------------------------------------------
// The block takes one item per clock on the request stream while the response
// side does not stall it. A load item (req_tuser = 0) writes one mask cell and
// gives no response; a pixel item (req_tuser = 1) gives exactly one response.
// The pipeline has five register stages: input capture with address
// generation, mask read, horizontal interpolation, vertical interpolation,
// and the color mix. The mask lives in four 1024 x 9 banks split by the
// parity of the cell column and row, so the four cells around a pixel always
// fall into different banks and are read in the same clock. Each stage holds
// its own valid bit, so bubbles close up behind a stalled response and a new
// request is taken whenever the first stage is free. Configuration writes are
// taken in any cycle, but must only be made while no pixel is in flight. Mask
// cells come up undefined after reset; a pixel must only read cells that were
// loaded before it.
module bilinear_mask_alpha_blend (
   input  logic                                clock,
   input  logic                                reset,

   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, from bit 0 up: mask_x, mask_y, weight, pixel_col, pixel_row,
   // dest_red, dest_green, dest_blue, src_red, src_green, src_blue, zero pad.
   input  logic [bmab_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: req_type (0 loads a mask cell, 1 blends a pixel).
   input  logic                                req_tuser,

   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, from bit 0 up: out_red, out_green, out_blue.
   output logic [bmab_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // tuser: blended (1 if the pixel was blended, 0 if it passed unchanged).
   output logic                                rsp_tuser,

   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  bmab_pkg::csr_index_type             csr_index,
   input  logic [bmab_pkg::REGION_W-1:0]       csr_data
);

   import bmab_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] dest_red;
      logic [CHAN_W-1:0] dest_green;
      logic [CHAN_W-1:0] dest_blue;
   } pix_type;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [SCALE_W-1:0]  scale_x_ff;
   logic [SCALE_W-1:0]  scale_y_ff;
   logic [REGION_W-1:0] region_w_ff;
   logic [REGION_W-1:0] region_h_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= '0;
         scale_y_ff  <= '0;
         region_w_ff <= REGION_W'(1);
         region_h_ff <= REGION_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCALE_X:  scale_x_ff  <= csr_data[SCALE_W-1:0];
            CSR_SCALE_Y:  scale_y_ff  <= csr_data[SCALE_W-1:0];
            CSR_REGION_W: region_w_ff <= csr_data;
            CSR_REGION_H: region_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage valid bits and flow control. A stage may take new data when it is
   // empty or when its content moves on in the same clock.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic kind1_ff;
   logic s1_load, s1_pixel;

   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;

   // A load leaves the first stage at once since it only writes the mask.
   assign s1_load  = v1_ff && (req_kind_type'(kind1_ff) == REQ_LOAD);
   assign s1_pixel = v1_ff && (req_kind_type'(kind1_ff) == REQ_PIXEL);
   assign rdy1     = !v1_ff || s1_load || rdy2;

   assign req_tready = rdy1;

   assign v1_in = rdy1 ? req_tvalid : v1_ff;
   assign v2_in = rdy2 ? s1_pixel   : v2_ff;
   assign v3_in = rdy3 ? v2_ff      : v3_ff;
   assign v4_in = rdy4 ? v3_ff      : v4_ff;
   assign v5_in = rdy5 ? v4_ff      : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture the request, then work out the mask position, the
   // fractions and the bank addresses.
   // ---------------------------------------------------------------------
   req_data_type req1_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         req1_ff  <= req_data_type'(req_tdata);
         kind1_ff <= req_tuser;
      end
   end

   logic [SCALE_W-1:0]     shift_x, shift_y;
   logic [COORD_W:0]       idx_x, idx_y;
   logic [2*FRAC_W-1:0]    frac_x_wide, frac_y_wide;
   logic [FRAC_W-1:0]      frac_x, frac_y;
   logic [REGION_W-1:0]    width_eff, height_eff;
   logic [REGION_W-1:0]    col_lim, row_lim;
   logic                   in_range, interp;
   logic [MASK_AW-1:0]     cx, cy, cx_p1, cy_p1;
   logic [BANK_AW-1:0]     rd_addr [NUM_BANKS];
   logic [1:0]             wr_bank;
   logic [BANK_AW-1:0]     wr_addr;
   logic [WEIGHT_W-1:0]    wr_data;

   assign shift_x = (scale_x_ff > SCALE_W'(SHIFT_MAX)) ? SCALE_W'(SHIFT_MAX) : scale_x_ff;
   assign shift_y = (scale_y_ff > SCALE_W'(SHIFT_MAX)) ? SCALE_W'(SHIFT_MAX) : scale_y_ff;

   assign idx_x = (COORD_W+1)'(req1_ff.pixel_col >> shift_x) + (COORD_W+1)'(MASK_OFFSET);
   assign idx_y = (COORD_W+1)'(req1_ff.pixel_row >> shift_y) + (COORD_W+1)'(MASK_OFFSET);

   // The bits shifted out of the coordinate land at the top of the Q8 fraction.
   assign frac_x_wide = {req1_ff.pixel_col[FRAC_W-1:0], {FRAC_W{1'b0}}} >> shift_x;
   assign frac_y_wide = {req1_ff.pixel_row[FRAC_W-1:0], {FRAC_W{1'b0}}} >> shift_y;
   assign frac_x      = frac_x_wide[FRAC_W-1:0];
   assign frac_y      = frac_y_wide[FRAC_W-1:0];

   // A zero region size counts as one; the last column or row takes the
   // nearest cell instead of interpolating.
   assign width_eff  = (region_w_ff == '0) ? REGION_W'(1) : region_w_ff;
   assign height_eff = (region_h_ff == '0) ? REGION_W'(1) : region_h_ff;
   assign col_lim    = width_eff - REGION_W'(1);
   assign row_lim    = height_eff - REGION_W'(1);
   assign interp     = ({1'b0, req1_ff.pixel_col} < col_lim) &&
                       ({1'b0, req1_ff.pixel_row} < row_lim);

   assign in_range = (idx_x < (COORD_W+1)'(MASK_LIMIT)) &&
                     (idx_y < (COORD_W+1)'(MASK_LIMIT));

   // An even bank holds the even member of the cell pair, an odd bank the odd
   // one; for an odd base index the even member is the one above it.
   assign cx    = idx_x[MASK_AW-1:0];
   assign cy    = idx_y[MASK_AW-1:0];
   assign cx_p1 = cx + MASK_AW'(1);
   assign cy_p1 = cy + MASK_AW'(1);

   always_comb begin
      for (int g = 0; g < NUM_BANKS; g++) begin
         rd_addr[g] = {(g >= 2) ? cy[MASK_AW-1:1] : cy_p1[MASK_AW-1:1],
                       (g % 2 == 1) ? cx[MASK_AW-1:1] : cx_p1[MASK_AW-1:1]};
      end
   end

   assign wr_bank = {req1_ff.mask_y[0], req1_ff.mask_x[0]};
   assign wr_addr = {req1_ff.mask_y[MASK_AW-1:1], req1_ff.mask_x[MASK_AW-1:1]};
   assign wr_data = (req1_ff.weight > WEIGHT_W'(Q8_ONE)) ? WEIGHT_W'(Q8_ONE)
                                                         : req1_ff.weight;

   // ---------------------------------------------------------------------
   // Mask banks: one write and one registered read per bank and clock.
   // ---------------------------------------------------------------------
   logic [WEIGHT_W-1:0] bank_rd_ff [NUM_BANKS];

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      logic [WEIGHT_W-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (s1_load && (wr_bank == 2'(g))) begin
            mem[wr_addr] <= wr_data;
         end
         if (rdy2) begin
            bank_rd_ff[g] <= mem[rd_addr[g]];
         end
      end
   end

   // Stage 2 side information.
   logic                par_x2_ff, par_y2_ff;
   logic [FRAC_W-1:0]   frac_x2_ff, frac_y2_ff;
   logic                in_range2_ff, interp2_ff;
   pix_type             pix2_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         par_x2_ff    <= cx[0];
         par_y2_ff    <= cy[0];
         frac_x2_ff   <= interp ? frac_x : '0;
         frac_y2_ff   <= interp ? frac_y : '0;
         in_range2_ff <= in_range;
         interp2_ff   <= interp;
         pix2_ff      <= '{src_red:    req1_ff.src_red,
                           src_green:  req1_ff.src_green,
                           src_blue:   req1_ff.src_blue,
                           dest_red:   req1_ff.dest_red,
                           dest_green: req1_ff.dest_green,
                           dest_blue:  req1_ff.dest_blue};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: route the banks to the four corner cells and interpolate along
   // the row. Cells that the pixel does not use are forced to zero, so a
   // nearest-cell pixel reduces to its base cell and an out-of-range pixel
   // to a zero weight.
   // ---------------------------------------------------------------------
   logic [WEIGHT_W-1:0] c00, c10, c01, c11;
   logic [WEIGHT_W-1:0] m00, m10, m01, m11;
   logic [WEIGHT_W-1:0] inv_fx;
   logic [2*WEIGHT_W-1:0] top_sum, bot_sum;

   always_comb begin
      case ({par_y2_ff, par_x2_ff})
         2'b00: begin
            c00 = bank_rd_ff[0]; c10 = bank_rd_ff[1];
            c01 = bank_rd_ff[2]; c11 = bank_rd_ff[3];
         end
         2'b01: begin
            c00 = bank_rd_ff[1]; c10 = bank_rd_ff[0];
            c01 = bank_rd_ff[3]; c11 = bank_rd_ff[2];
         end
         2'b10: begin
            c00 = bank_rd_ff[2]; c10 = bank_rd_ff[3];
            c01 = bank_rd_ff[0]; c11 = bank_rd_ff[1];
         end
         default: begin
            c00 = bank_rd_ff[3]; c10 = bank_rd_ff[2];
            c01 = bank_rd_ff[1]; c11 = bank_rd_ff[0];
         end
      endcase
   end

   assign m00 = in_range2_ff ? c00 : '0;
   assign m10 = (in_range2_ff && interp2_ff) ? c10 : '0;
   assign m01 = (in_range2_ff && interp2_ff) ? c01 : '0;
   assign m11 = (in_range2_ff && interp2_ff) ? c11 : '0;

   assign inv_fx  = WEIGHT_W'(Q8_ONE) - {1'b0, frac_x2_ff};
   assign top_sum = m00 * inv_fx + m10 * {1'b0, frac_x2_ff};
   assign bot_sum = m01 * inv_fx + m11 * {1'b0, frac_x2_ff};

   logic [2*WEIGHT_W-2:0] top3_ff, bot3_ff;
   logic [FRAC_W-1:0]     frac_y3_ff;
   pix_type               pix3_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         top3_ff    <= top_sum[2*WEIGHT_W-2:0];
         bot3_ff    <= bot_sum[2*WEIGHT_W-2:0];
         frac_y3_ff <= frac_y2_ff;
         pix3_ff    <= pix2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: interpolate between the rows and drop the two Q8 fractions.
   // ---------------------------------------------------------------------
   localparam int VSUM_W = 2 * WEIGHT_W - 1 + WEIGHT_W;

   logic [WEIGHT_W-1:0] inv_fy;
   logic [VSUM_W-1:0]   vert_sum;
   logic [WEIGHT_W-1:0] weight_raw, weight_sat;

   assign inv_fy     = WEIGHT_W'(Q8_ONE) - {1'b0, frac_y3_ff};
   assign vert_sum   = top3_ff * inv_fy + bot3_ff * {1'b0, frac_y3_ff};
   assign weight_raw = vert_sum[2*FRAC_W +: WEIGHT_W];
   assign weight_sat = (weight_raw > WEIGHT_W'(Q8_ONE)) ? WEIGHT_W'(Q8_ONE) : weight_raw;

   logic [WEIGHT_W-1:0] weight4_ff;
   pix_type             pix4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         weight4_ff <= weight_sat;
         pix4_ff    <= pix3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: mix each channel. A zero weight gives back the destination
   // bytes exactly, so the unchanged case needs no separate path.
   // ---------------------------------------------------------------------
   localparam int MIX_W = CHAN_W + WEIGHT_W;

   logic [WEIGHT_W-1:0] inv_w;
   logic [MIX_W-1:0]    mix_red, mix_green, mix_blue;
   rsp_data_type        rsp_data_in;

   assign inv_w     = WEIGHT_W'(Q8_ONE) - weight4_ff;
   assign mix_red   = pix4_ff.src_red   * weight4_ff + pix4_ff.dest_red   * inv_w;
   assign mix_green = pix4_ff.src_green * weight4_ff + pix4_ff.dest_green * inv_w;
   assign mix_blue  = pix4_ff.src_blue  * weight4_ff + pix4_ff.dest_blue  * inv_w;

   assign rsp_data_in = '{out_blue:  mix_blue[FRAC_W +: CHAN_W],
                          out_green: mix_green[FRAC_W +: CHAN_W],
                          out_red:   mix_red[FRAC_W +: CHAN_W]};

   // ---------------------------------------------------------------------
   // Stage 5: response register.
   // ---------------------------------------------------------------------
   rsp_data_type rsp_data_ff;
   logic         blended_ff;

   always_ff @(posedge clock) begin
      if (rdy5) begin
         rsp_data_ff <= rsp_data_in;
         blended_ff  <= (weight4_ff != '0);
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = blended_ff;

endmodule

// ===== sim/bmab_checker.sv =====
// ----------------------------------------------------------------------------
// Bilinear mask alpha blend checker
// Watches the request, response and register channels of the blend block,
// keeps its own mask and registers, predicts each pixel response and compares
// the responses in order.
// ----------------------------------------------------------------------------
module bmab_checker
   import bmab_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,

   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,

   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [REGION_W-1:0]    csr_data,

   output int unsigned            error_count,
   output int unsigned            pending_count
);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              blended;
   } pixel_result_type;

   bit   [WEIGHT_W-1:0] mask_cells [MASK_DIM*MASK_DIM];
   logic [SCALE_W-1:0]  scale_x;
   logic [SCALE_W-1:0]  scale_y;
   logic [REGION_W-1:0] region_w;
   logic [REGION_W-1:0] region_h;

   pixel_result_type expected_pixels [$];

   // The cell index wraps at the size of the store.
   function automatic int unsigned mask_at(int unsigned x, int unsigned y);
      return mask_cells[(2*MASK_AW)'(x + y * MASK_DIM)];
   endfunction

   function automatic int unsigned mix_channel(int unsigned src, int unsigned dst,
                                               int unsigned w);
      return ((src * w + dst * (Q8_ONE - w)) >> 8) & 8'hFF;
   endfunction

   function automatic pixel_result_type blend_pixel(req_data_type d);
      int unsigned col, row, sx, sy, x, y, fx, fy, rw, rh, top_sum, bot_sum, w;
      pixel_result_type res;
      col = d.pixel_col;
      row = d.pixel_row;
      sx  = (scale_x > SHIFT_MAX) ? SHIFT_MAX : scale_x;
      sy  = (scale_y > SHIFT_MAX) ? SHIFT_MAX : scale_y;
      x   = (col >> sx) + MASK_OFFSET;
      y   = (row >> sy) + MASK_OFFSET;
      fx  = (col & ((1 << sx) - 1)) << (FRAC_W - sx);
      fy  = (row & ((1 << sy) - 1)) << (FRAC_W - sy);
      rw  = (region_w == 0) ? 1 : region_w;
      rh  = (region_h == 0) ? 1 : region_h;
      w   = 0;
      if (x < MASK_LIMIT && y < MASK_LIMIT) begin
         if (col < rw - 1 && row < rh - 1) begin
            top_sum = mask_at(x, y) * (Q8_ONE - fx) + mask_at(x + 1, y) * fx;
            bot_sum = mask_at(x, y + 1) * (Q8_ONE - fx) + mask_at(x + 1, y + 1) * fx;
            w = (top_sum * (Q8_ONE - fy) + bot_sum * fy) >> 16;
         end else begin
            w = mask_at(x, y);
         end
         if (w > Q8_ONE) w = Q8_ONE;
      end
      if (w > 0) begin
         res.red     = CHAN_W'(mix_channel(d.src_red, d.dest_red, w));
         res.green   = CHAN_W'(mix_channel(d.src_green, d.dest_green, w));
         res.blue    = CHAN_W'(mix_channel(d.src_blue, d.dest_blue, w));
         res.blended = 1'b1;
      end else begin
         res.red     = d.dest_red;
         res.green   = d.dest_green;
         res.blue    = d.dest_blue;
         res.blended = 1'b0;
      end
      return res;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      req_data_type     item;
      rsp_data_type     word;
      pixel_result_type want;
      int unsigned      wt;
      if (reset) begin
         scale_x     = '0;
         scale_y     = '0;
         region_w    = REGION_W'(1);
         region_h    = REGION_W'(1);
         error_count = 0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCALE_X:  scale_x  = csr_data[SCALE_W-1:0];
               CSR_SCALE_Y:  scale_y  = csr_data[SCALE_W-1:0];
               CSR_REGION_W: region_w = csr_data;
               CSR_REGION_H: region_h = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            item = req_data_type'(req_tdata);
            if (req_tuser == REQ_LOAD) begin
               wt = item.weight;
               if (wt > Q8_ONE) wt = Q8_ONE;
               mask_cells[{item.mask_y, item.mask_x}] = WEIGHT_W'(wt);
            end else begin
               expected_pixels.push_back(blend_pixel(item));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            word = rsp_data_type'(rsp_tdata);
            if (expected_pixels.size() == 0) begin
               $display("%0t: response with no pixel pending, expected none, got %h/%b",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("out_red", want.red, word.out_red);
               check_field("out_green", want.green, word.out_green);
               check_field("out_blue", want.blue, word.out_blue);
               check_field("blended", want.blended, rsp_tuser);
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Bilinear mask alpha blend testbench
// Drives load and pixel items into the blend block under several register
// settings, with random idle gaps on both streams, and lets a checker predict
// and compare every pixel response.
// ----------------------------------------------------------------------------
module tb;
   import bmab_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int CYCLE_LIMIT     = 1_000_000;
   // A load leaves the pipeline in the clock after its transfer, so a short drain
   // after the last pixel response covers a trailing load.
   localparam int DRAIN_CYCLES    = 10;
   localparam int END_CYCLES      = 20;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_ITEMS     = 75;
   localparam int NUM_PHASES      = 6;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   csr_index_type          csr_index;
   logic [REGION_W-1:0]    csr_data;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;

   // The stimulus keeps track of which mask cells it has loaded, so that no
   // pixel ever reads a cell that still holds its undefined power-up value.
   bit cell_loaded [MASK_DIM*MASK_DIM];

   // Effective register values, used only to steer pixel positions.
   int shift_x, shift_y, width_eff, height_eff;

   // Set by the stimulus to ask the receiver for one long hold-off; calm turns
   // off all random idling on both streams.
   bit hold_off_req = 1'b0;
   bit calm         = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   bilinear_mask_alpha_blend u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bmab_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // A hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Idle stretches are mostly short, with an occasional long one.
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Load weights lean on the special values: zero, full scale and the
   // saturating range above it.
   function automatic int random_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 25) return Q8_ONE;
      if (r < 35) return $urandom_range(Q8_ONE + 1, 511);
      return $urandom_range(1, Q8_ONE - 1);
   endfunction

   // Picks a pixel coordinate along one axis. Most land on a mask index that
   // the block blends, some sit on the last column or row of the region, some
   // sit just past the mask limit, and the rest roam the whole field.
   function automatic int pick_coord(int shift, int extent);
      int r, top_idx, c;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         c = (extent - 1 > 4095) ? 4095 : extent - 1;
      end else if (r < 30) begin
         c = $urandom_range(0, 4095);
      end else if (r < 38) begin
         c = ((MASK_LIMIT - MASK_OFFSET) << shift) | ($urandom & ((1 << shift) - 1));
         if (c > 4095) c = $urandom_range(0, 4095);
      end else begin
         top_idx = 4095 >> shift;
         if (top_idx > MASK_LIMIT - MASK_OFFSET - 1) top_idx = MASK_LIMIT - MASK_OFFSET - 1;
         c = ($urandom_range(0, top_idx) << shift) | ($urandom & ((1 << shift) - 1));
      end
      return c;
   endfunction

   // Every field starts random; the caller overrides the ones that matter.
   function automatic req_data_type random_fields();
      req_data_type d;
      d     = req_data_type'({$urandom, $urandom, $urandom, $urandom});
      d.pad = '0;
      return d;
   endfunction

   function automatic logic [REGION_W-1:0] scale_word(int s);
      logic [REGION_W-1:0] v;
      v = REGION_W'(s & 4'hF);
      // The register keeps only its low bits, so junk above them is harmless.
      if ($urandom_range(0, 1)) v = v | (REGION_W'($urandom) & 13'h1FF0);
      return v;
   endfunction

   // Offers one item and returns at the falling edge after its transfer. The
   // valid is only lowered when a gap follows, so it never drops and rises in
   // the same step.
   task automatic send_item(req_kind_type kind, req_data_type data);
      int gap;
      gap = (calm || $urandom_range(0, 99) >= 25) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic load_cell(int x, int y, int wt);
      req_data_type d;
      d        = random_fields();
      d.mask_x = MASK_AW'(x);
      d.mask_y = MASK_AW'(y);
      d.weight = WEIGHT_W'(wt);
      cell_loaded[(2*MASK_AW)'(x + y * MASK_DIM)] = 1'b1;
      send_item(REQ_LOAD, d);
   endtask

   // Sends a pixel, first loading any of its four neighbor cells that have
   // never been written if its mask position is below the mask limit.
   task automatic blend_at(int col, int row, logic [23:0] dest, logic [23:0] src);
      req_data_type d;
      int x, y;
      x = (col >> shift_x) + MASK_OFFSET;
      y = (row >> shift_y) + MASK_OFFSET;
      if (x < MASK_LIMIT && y < MASK_LIMIT) begin
         for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
               if (!cell_loaded[(2*MASK_AW)'((x + dx) + (y + dy) * MASK_DIM)])
                  load_cell(x + dx, y + dy, random_weight());
            end
         end
      end
      d            = random_fields();
      d.pixel_col  = COORD_W'(col);
      d.pixel_row  = COORD_W'(row);
      d.dest_red   = dest[7:0];
      d.dest_green = dest[15:8];
      d.dest_blue  = dest[23:16];
      d.src_red    = src[7:0];
      d.src_green  = src[15:8];
      d.src_blue   = src[23:16];
      send_item(REQ_PIXEL, d);
   endtask

   // Waits until every pixel response has come back and any trailing load has
   // left the pipeline.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [REGION_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_config(int sx, int sy, int rw, int rh);
      wait_idle();
      write_csr(CSR_SCALE_X, scale_word(sx));
      write_csr(CSR_SCALE_Y, scale_word(sy));
      write_csr(CSR_REGION_W, REGION_W'(rw));
      write_csr(CSR_REGION_H, REGION_W'(rh));
      csr_valid  <= 1'b0;
      shift_x    = (sx > SHIFT_MAX) ? SHIFT_MAX : sx;
      shift_y    = (sy > SHIFT_MAX) ? SHIFT_MAX : sy;
      width_eff  = (rw == 0) ? 1 : rw;
      height_eff = (rh == 0) ? 1 : rh;
   endtask

   // Response side: random stalls, plus one long hold-off on request that
   // lets the pipeline fill up and push back on the request stream.
   initial begin : receiver
      int stall_left;
      bit hold_off_done;
      stall_left    = 0;
      hold_off_done = 1'b0;
      rsp_tready    = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            stall_left    = HOLD_OFF_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int start;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_LOAD;
      csr_valid  = 1'b0;
      csr_index  = CSR_SCALE_X;
      csr_data   = '0;
      shift_x    = 0;
      shift_y    = 0;
      width_eff  = 1;
      height_eff = 1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset settings, where the region is a single
      // pixel and every pixel takes its nearest cell.
      load_cell(2, 2, 0);                              // zero weight passes through
      blend_at(0, 0, 24'h804020, 24'hFFFFFF);
      load_cell(2, 2, Q8_ONE);                         // full source
      blend_at(0, 0, 24'h000000, 24'hFFFFFF);
      load_cell(2, 2, 511);                            // saturates to full scale
      blend_at(0, 0, 24'hFFFFFF, 24'h000000);
      load_cell(2, 2, 128);                            // half and half
      blend_at(0, 0, 24'hFFFFFF, 24'hFFFFFF);
      blend_at(0, 0, 24'h000000, 24'hFFFFFF);
      blend_at(47, 0, 24'h123456, 24'hABCDEF);         // column index at the limit
      blend_at(0, 47, 24'h654321, 24'hFEDCBA);         // row index at the limit
      blend_at(4095, 4095, 24'hFFFFFF, 24'h000000);
      blend_at(46, 46, 24'h00FF00, 24'hFF00FF);        // deepest cell, beyond the region
      load_cell(63, 63, 300);

      // Coarsest scale over the widest region: full fractions and the edge.
      set_config(8, 8, 4096, 4096);
      blend_at(128, 128, 24'h102030, 24'hF0E0D0);
      blend_at(255, 1, 24'h000000, 24'hFFFFFF);
      blend_at(4094, 4094, 24'hFFFFFF, 24'h000000);
      blend_at(4095, 4095, 24'h7F7F7F, 24'h808080);

      // Random phases, each under its own register setting.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: set_config(0, 0, 0, 0);
            1: set_config(3, 1, $urandom_range(1, 64), $urandom_range(1, 64));
            2: set_config(15, 9, 8191, 8191);
            3: set_config(2, 5, $urandom_range(1, 300), $urandom_range(1, 300));
            4: set_config($urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 8191), $urandom_range(0, 8191));
            default: set_config(4, 4, 4096, 1);
         endcase
         calm = (p == 3);
         if (p == 1) hold_off_req = 1'b1;
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 30)
               load_cell($urandom_range(0, MASK_DIM - 1), $urandom_range(0, MASK_DIM - 1),
                         random_weight());
            else
               blend_at(pick_coord(shift_x, width_eff), pick_coord(shift_y, height_eff),
                        24'($urandom), 24'($urandom));
         end
         calm = 1'b0;
      end

      wait_idle();
      repeat (END_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/bmab_pkg.sv
rtl/core/bilinear_mask_alpha_blend.sv
sim/bmab_checker.sv
sim/tb.sv
